@@ design/euler_angles_to_rigid_matrix_unit_defines.svh @@
// Assertion macros shared by the Euler pose to rigid matrix design.
// Every user must have clk_i and rst_ni in scope; no other dependencies.
`ifndef EULER_ANGLES_TO_RIGID_MATRIX_UNIT_DEFINES_SVH
`define EULER_ANGLES_TO_RIGID_MATRIX_UNIT_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define EBRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define EBRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ebrm_pkg.sv @@
// Shared constants and types for the Euler pose to rigid matrix pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package ebrm_pkg;

  localparam int unsigned DEF_SINE_TABLE_ENTRIES = 1024;
  localparam int unsigned DEF_COEF_WIDTH         = 16;

  localparam int TRANS_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int ENTRY_WIDTH = 16;
  localparam int ENTRY_FRAC  = 14;
  localparam int ENTRY_ONE   = 16384;

  // Register stages of the angle front end and of the matrix back end.
  localparam int ANGLE_STAGES  = 7;
  localparam int MATRIX_STAGES = 3;
  localparam int PIPE_DEPTH    = ANGLE_STAGES + MATRIX_STAGES;

  // Load enables per stage; packed so that bit k is stage k overall.
  typedef struct packed {
    logic [MATRIX_STAGES-1:0] matrix;
    logic [ANGLE_STAGES-1:0]  angle;
  } stage_en_t;

endpackage

`default_nettype wire

@@ design/ebrm_pipe_ctrl.sv @@
// Valid bits and per-stage load enables of the pipeline.
// Depends on ebrm_pkg and the assertion macro header.
`default_nettype none
`include "euler_angles_to_rigid_matrix_unit_defines.svh"

module ebrm_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ebrm_pkg::stage_en_t en_o
);

  localparam int Depth = ebrm_pkg::PIPE_DEPTH;

  logic [Depth-1:0] valid_q, valid_d;
  logic [Depth-1:0] en;

  // A stage may load when it is empty or when the stage after it moves on,
  // so bubbles are squeezed out while the output is stalled.
  always_comb begin
    en[Depth-1] = !valid_q[Depth-1] || out_ready_i;
    for (int k = Depth - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < Depth; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[Depth-1];
  assign en_o        = ebrm_pkg::stage_en_t'(en);

  `EBRM_ASSERT_IMP(a_full_when_blocked, !in_ready_o, &valid_q,
                   "input blocked although the pipeline has a free stage")
  `EBRM_ASSERT_IMP(a_accept_enters, $past(rst_ni) && $past(in_valid_i && in_ready_o),
                   valid_q[0], "accepted transaction did not enter the first stage")
  `EBRM_ASSERT_IMP(a_items_conserved, $past(rst_ni),
                   $countones(valid_q) == $past($countones(valid_q))
                   + int'($past(in_valid_i && in_ready_o))
                   - int'($past(out_valid_o && out_ready_i)),
                   "transaction lost or duplicated inside the pipeline")

endmodule

`default_nettype wire

@@ design/ebrm_sincos.sv @@
// Angle front end: reduction modulo one turn, table index and quarter-wave
// sine table lookup for sine and cosine of one angle. Depends on ebrm_pkg.
`default_nettype none

module ebrm_sincos #(
  parameter int unsigned SINE_TABLE_ENTRIES = ebrm_pkg::DEF_SINE_TABLE_ENTRIES,
  parameter int unsigned COEF_WIDTH         = ebrm_pkg::DEF_COEF_WIDTH
) (
  input  logic                                    clk_i,
  input  logic [ebrm_pkg::ANGLE_STAGES-1:0]       en_i,
  input  logic signed [ebrm_pkg::ANGLE_WIDTH-1:0] angle_i,
  output logic signed [COEF_WIDTH-1:0]            sin_o,
  output logic signed [COEF_WIDTH-1:0]            cos_o
);

  localparam int FRAC   = COEF_WIDTH - 2;
  localparam int MAG_W  = COEF_WIDTH - 1;
  localparam int ADDR_W = $clog2(SINE_TABLE_ENTRIES + 1);

  localparam int TURN_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam int HALF_QUARTER  = 2880;
  localparam int ANG_W         = 15;
  localparam int REM_W         = 13;
  localparam int LANES         = 2;
  localparam int LANE_COS      = 1;

  // idx = floor((r * N + 2880) / 5760), by multiplication with a rounded-up
  // reciprocal that is exact for every y below 2^Y_W.
  localparam longint unsigned Y_MAX =
    longint'(QUARTER_UNITS) * longint'(SINE_TABLE_ENTRIES) + HALF_QUARTER;
  localparam int Y_W          = $clog2(Y_MAX + 1);
  localparam int RECIP_SHIFT  = Y_W + REM_W;
  localparam longint unsigned RECIP =
    ((longint'(1) << RECIP_SHIFT) + QUARTER_UNITS - 1) / QUARTER_UNITS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = Y_W + RECIP_W;

  localparam logic signed [17:0] TURN_S    = 18'(TURN_UNITS);
  localparam logic signed [17:0] QUARTER_S = 18'(QUARTER_UNITS);

  localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
  localparam logic [63:0] NUM_ENTRIES = 64'(SINE_TABLE_ENTRIES);
  localparam int          SERIES_TERMS = 14;
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // Table entry k is sin(90 deg * k / N), evaluated by Taylor series in Q3.61.
  function automatic logic [MAG_W-1:0] rom_entry(input int unsigned k);
    logic [63:0] kk, x, x2, sum, term, rnd;
    kk   = 64'(k);
    x    = (HALF_PI_Q61 / NUM_ENTRIES) * kk + ((HALF_PI_Q61 % NUM_ENTRIES) * kk) / NUM_ENTRIES;
    x2   = mul_q61(x, x);
    sum  = x;
    term = x;
    for (int i = 0; i < SERIES_TERMS; i++) begin
      term = mul_q61(term, x2) / SERIES_DIV[i];
      if (!i[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rnd = (sum + (64'd1 << (60 - FRAC))) >> (61 - FRAC);
    return MAG_W'(rnd);
  endfunction

  function automatic logic [ANG_W-1:0] reduce_turn(input logic signed [17:0] v);
    logic signed [17:0] w;
    if (v < -TURN_S) begin
      w = v + TURN_S + TURN_S;
    end else if (v < 18'sd0) begin
      w = v + TURN_S;
    end else if (v >= TURN_S) begin
      w = v - TURN_S;
    end else begin
      w = v;
    end
    return w[ANG_W-1:0];
  endfunction

  logic [MAG_W-1:0] rom [SINE_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = rom_entry(k);
    assign rom[k] = ENTRY;
  end

  // Lane 0 carries the angle itself, lane 1 the angle plus a quarter turn.
  logic [ANG_W-1:0]  ang_q   [LANES];
  logic [1:0]        quad1_q [LANES];
  logic [REM_W-1:0]  rem_q   [LANES];
  logic [1:0]        quad2_q [LANES];
  logic [Y_W-1:0]    y_q     [LANES];
  logic [1:0]        quad3_q [LANES];
  logic [ADDR_W-1:0] idx_q   [LANES];
  logic              neg4_q  [LANES];
  logic [ADDR_W-1:0] addr_q  [LANES];
  logic              neg5_q  [LANES];
  logic [MAG_W-1:0]  mag_q   [LANES];
  logic signed [COEF_WIDTH-1:0] coef_q [LANES];

  logic signed [17:0]  turn_in [LANES];
  logic [ANG_W-1:0]    ang_d   [LANES];
  logic [1:0]          quad_d  [LANES];
  logic [REM_W-1:0]    rem_d   [LANES];
  logic [Y_W-1:0]      y_d     [LANES];
  logic [PROD_W-1:0]   prod    [LANES];
  logic [ADDR_W-1:0]   idx_d   [LANES];
  logic [ADDR_W-1:0]   addr_d  [LANES];
  logic signed [COEF_WIDTH-1:0] mag_s  [LANES];
  logic signed [COEF_WIDTH-1:0] coef_d [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      turn_in[l] = 18'(angle_i);
      if (l == LANE_COS) begin
        turn_in[l] = turn_in[l] + QUARTER_S;
      end
      ang_d[l] = reduce_turn(turn_in[l]);

      if (ang_q[l] >= ANG_W'(3 * QUARTER_UNITS)) begin
        quad_d[l] = 2'd3;
        rem_d[l]  = REM_W'(ang_q[l] - ANG_W'(3 * QUARTER_UNITS));
      end else if (ang_q[l] >= ANG_W'(2 * QUARTER_UNITS)) begin
        quad_d[l] = 2'd2;
        rem_d[l]  = REM_W'(ang_q[l] - ANG_W'(2 * QUARTER_UNITS));
      end else if (ang_q[l] >= ANG_W'(QUARTER_UNITS)) begin
        quad_d[l] = 2'd1;
        rem_d[l]  = REM_W'(ang_q[l] - ANG_W'(QUARTER_UNITS));
      end else begin
        quad_d[l] = 2'd0;
        rem_d[l]  = REM_W'(ang_q[l]);
      end

      y_d[l]    = Y_W'(rem_q[l]) * Y_W'(SINE_TABLE_ENTRIES) + Y_W'(HALF_QUARTER);
      prod[l]   = PROD_W'(y_q[l]) * PROD_W'(RECIP);
      idx_d[l]  = ADDR_W'(prod[l] >> RECIP_SHIFT);
      // Odd quadrants read the table backwards.
      addr_d[l] = quad3_q[l][0] ? ADDR_W'(SINE_TABLE_ENTRIES) - idx_q[l] : idx_q[l];
      mag_s[l]  = $signed({1'b0, mag_q[l]});
      coef_d[l] = neg5_q[l] ? -mag_s[l] : mag_s[l];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (en_i[0]) begin
        ang_q[l] <= ang_d[l];
      end
      if (en_i[1]) begin
        quad1_q[l] <= quad_d[l];
        rem_q[l]   <= rem_d[l];
      end
      if (en_i[2]) begin
        quad2_q[l] <= quad1_q[l];
        y_q[l]     <= y_d[l];
      end
      if (en_i[3]) begin
        quad3_q[l] <= quad2_q[l];
        idx_q[l]   <= idx_d[l];
      end
      if (en_i[4]) begin
        neg4_q[l] <= quad3_q[l][1];
        addr_q[l] <= addr_d[l];
      end
      if (en_i[5]) begin
        neg5_q[l] <= neg4_q[l];
        mag_q[l]  <= rom[addr_q[l]];
      end
      if (en_i[6]) begin
        coef_q[l] <= coef_d[l];
      end
    end
  end

  assign sin_o = coef_q[0];
  assign cos_o = coef_q[LANE_COS];

endmodule

`default_nettype wire

@@ design/ebrm_matrix.sv @@
// Matrix back end: coefficient products, the rounded triple products, the
// sums and the final rounding and saturation to Q1.14. Depends on ebrm_pkg.
`default_nettype none

module ebrm_matrix #(
  parameter int unsigned COEF_WIDTH = ebrm_pkg::DEF_COEF_WIDTH
) (
  input  logic                                     clk_i,
  input  logic [ebrm_pkg::MATRIX_STAGES-1:0]       en_i,
  input  logic signed [COEF_WIDTH-1:0]             sin_x_i,
  input  logic signed [COEF_WIDTH-1:0]             cos_x_i,
  input  logic signed [COEF_WIDTH-1:0]             sin_y_i,
  input  logic signed [COEF_WIDTH-1:0]             cos_y_i,
  input  logic signed [COEF_WIDTH-1:0]             sin_z_i,
  input  logic signed [COEF_WIDTH-1:0]             cos_z_i,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m00_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m01_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m02_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m10_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m11_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m12_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m20_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m21_o,
  output logic signed [ebrm_pkg::ENTRY_WIDTH-1:0]  m22_o
);

  localparam int FRAC      = COEF_WIDTH - 2;
  localparam int PW        = 2 * COEF_WIDTH;
  localparam int EW        = ebrm_pkg::ENTRY_WIDTH;
  localparam int OUT_SHIFT = 2 * FRAC - ebrm_pkg::ENTRY_FRAC;

  localparam logic signed [PW-1:0] COEF_HALF  = PW'(64'd1 << (FRAC - 1));
  localparam logic signed [PW-1:0] ENTRY_HALF = PW'(64'd1 << (OUT_SHIFT - 1));
  localparam logic signed [PW-1:0] ENTRY_MAX  = PW'(ebrm_pkg::ENTRY_ONE);
  localparam logic signed [PW-1:0] ENTRY_MIN  = -ENTRY_MAX;
  localparam logic signed [EW-1:0] SAT_POS    = EW'(ebrm_pkg::ENTRY_ONE);
  localparam logic signed [EW-1:0] SAT_NEG    = -SAT_POS;

  // Product at scale 2F back to F fraction bits, ties toward plus infinity.
  function automatic logic signed [COEF_WIDTH-1:0] round_coef(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = v + COEF_HALF;
    return s[FRAC +: COEF_WIDTH];
  endfunction

  function automatic logic signed [EW-1:0] to_entry(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    logic signed [EW-1:0] e;
    r = (v + ENTRY_HALF) >>> OUT_SHIFT;
    if (r > ENTRY_MAX) begin
      e = SAT_POS;
    end else if (r < ENTRY_MIN) begin
      e = SAT_NEG;
    end else begin
      e = EW'(r);
    end
    return e;
  endfunction

  // First stage: all two-coefficient products, the negated scaled sin_y and the z coefficients.
  logic signed [PW-1:0] sxsy_q, cxsy_q, cycz_q, cysz_q, sxcy_q, cxcy_q;
  logic signed [PW-1:0] cxsz_q, cxcz_q, sxsz_q, sxcz_q, nsy_q;
  logic signed [COEF_WIDTH-1:0] cz_q, sz_q;

  // Second stage: triple products and the terms carried alongside.
  logic signed [PW-1:0] tcz_q, tsz_q, ucz_q, usz_q;
  logic signed [PW-1:0] cycz2_q, cysz2_q, sxcy2_q, cxcy2_q, nsy2_q;
  logic signed [PW-1:0] cxsz2_q, cxcz2_q, sxsz2_q, sxcz2_q;

  logic signed [COEF_WIDTH-1:0] t_c, u_c;
  logic signed [PW-1:0] m10_w, m11_w, m20_w, m21_w;

  assign t_c = round_coef(sxsy_q);
  assign u_c = round_coef(cxsy_q);

  assign m10_w = tcz_q - cxsz2_q;
  assign m11_w = tsz_q + cxcz2_q;
  assign m20_w = ucz_q + sxsz2_q;
  assign m21_w = usz_q - sxcz2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sxsy_q <= PW'(sin_x_i) * PW'(sin_y_i);
      cxsy_q <= PW'(cos_x_i) * PW'(sin_y_i);
      cycz_q <= PW'(cos_y_i) * PW'(cos_z_i);
      cysz_q <= PW'(cos_y_i) * PW'(sin_z_i);
      sxcy_q <= PW'(sin_x_i) * PW'(cos_y_i);
      cxcy_q <= PW'(cos_x_i) * PW'(cos_y_i);
      cxsz_q <= PW'(cos_x_i) * PW'(sin_z_i);
      cxcz_q <= PW'(cos_x_i) * PW'(cos_z_i);
      sxsz_q <= PW'(sin_x_i) * PW'(sin_z_i);
      sxcz_q <= PW'(sin_x_i) * PW'(cos_z_i);
      nsy_q  <= -(PW'(sin_y_i) <<< FRAC);
      cz_q   <= cos_z_i;
      sz_q   <= sin_z_i;
    end
    if (en_i[1]) begin
      tcz_q   <= PW'(t_c) * PW'(cz_q);
      tsz_q   <= PW'(t_c) * PW'(sz_q);
      ucz_q   <= PW'(u_c) * PW'(cz_q);
      usz_q   <= PW'(u_c) * PW'(sz_q);
      cycz2_q <= cycz_q;
      cysz2_q <= cysz_q;
      sxcy2_q <= sxcy_q;
      cxcy2_q <= cxcy_q;
      nsy2_q  <= nsy_q;
      cxsz2_q <= cxsz_q;
      cxcz2_q <= cxcz_q;
      sxsz2_q <= sxsz_q;
      sxcz2_q <= sxcz_q;
    end
    if (en_i[2]) begin
      m00_o <= to_entry(cycz2_q);
      m01_o <= to_entry(cysz2_q);
      m02_o <= to_entry(nsy2_q);
      m10_o <= to_entry(m10_w);
      m11_o <= to_entry(m11_w);
      m12_o <= to_entry(sxcy2_q);
      m20_o <= to_entry(m20_w);
      m21_o <= to_entry(m21_w);
      m22_o <= to_entry(cxcy2_q);
    end
  end

endmodule

`default_nettype wire

@@ design/euler_angles_to_rigid_matrix_unit.sv @@
// Top level of the Euler pose to rigid matrix block.
// Depends on ebrm_pkg, ebrm_pipe_ctrl, ebrm_sincos, ebrm_matrix and the macro header.
//
// Usage:
//   The slave channel takes one pose per transaction: tdata holds trans_x,
//   trans_y, trans_z (Q16.16) and rot_x, rot_y, rot_z (1/64 degree units).
//   The master channel returns one transaction per pose: the nine Q1.14
//   rotation entries m00..m22 followed by the translation column.
//   From acceptance to tvalid on the master side a pose passes through
//   seven stages of angle reduction, index arithmetic and sine table read,
//   then three stages of products, triple products and rounding.
//   Throughput is one pose per cycle unless the receiver stalls it; the three
//   sine tables each serve a sine and a cosine read in the same cycle, so no
//   unit is shared. When the receiver holds m_axis_tready low the result stays
//   on the port, and empty stages further up keep filling, so s_axis_tready
//   only drops once all ten stages hold a pose. Nothing is dropped or repeated.
//   Reset clears every valid bit; the sine tables are constant and need no
//   filling, so the block accepts a pose in the first cycle after reset.
`default_nettype none
`include "euler_angles_to_rigid_matrix_unit_defines.svh"

module euler_angles_to_rigid_matrix_unit #(
  parameter int unsigned SINE_TABLE_ENTRIES = ebrm_pkg::DEF_SINE_TABLE_ENTRIES,
  parameter int unsigned COEF_WIDTH         = ebrm_pkg::DEF_COEF_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // trans_x, trans_y, trans_z (32 bits each), rot_x, rot_y, rot_z (16 bits each)
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each),
  // col_x, col_y, col_z (32 bits each)
  output logic [239:0] m_axis_tdata
);

  localparam int Depth = ebrm_pkg::PIPE_DEPTH;
  localparam int TW    = ebrm_pkg::TRANS_WIDTH;
  localparam int AW    = ebrm_pkg::ANGLE_WIDTH;
  localparam int EW    = ebrm_pkg::ENTRY_WIDTH;

  ebrm_pkg::stage_en_t stage_en;
  logic [Depth-1:0]    en_flat;

  logic signed [AW-1:0] rot_x, rot_y, rot_z;
  logic signed [COEF_WIDTH-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
  logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic [3*TW-1:0] trans_q [Depth];

  assign rot_x   = s_axis_tdata[3*TW +: AW];
  assign rot_y   = s_axis_tdata[3*TW+AW +: AW];
  assign rot_z   = s_axis_tdata[3*TW+2*AW +: AW];
  assign en_flat = stage_en;

  ebrm_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .en_o        (stage_en)
  );

  ebrm_sincos #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .COEF_WIDTH         (COEF_WIDTH)
  ) u_sincos_x (
    .clk_i   (clk_i),
    .en_i    (stage_en.angle),
    .angle_i (rot_x),
    .sin_o   (sin_x),
    .cos_o   (cos_x)
  );

  ebrm_sincos #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .COEF_WIDTH         (COEF_WIDTH)
  ) u_sincos_y (
    .clk_i   (clk_i),
    .en_i    (stage_en.angle),
    .angle_i (rot_y),
    .sin_o   (sin_y),
    .cos_o   (cos_y)
  );

  ebrm_sincos #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .COEF_WIDTH         (COEF_WIDTH)
  ) u_sincos_z (
    .clk_i   (clk_i),
    .en_i    (stage_en.angle),
    .angle_i (rot_z),
    .sin_o   (sin_z),
    .cos_o   (cos_z)
  );

  ebrm_matrix #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_matrix (
    .clk_i   (clk_i),
    .en_i    (stage_en.matrix),
    .sin_x_i (sin_x),
    .cos_x_i (cos_x),
    .sin_y_i (sin_y),
    .cos_y_i (cos_y),
    .sin_z_i (sin_z),
    .cos_z_i (cos_z),
    .m00_o   (m00),
    .m01_o   (m01),
    .m02_o   (m02),
    .m10_o   (m10),
    .m11_o   (m11),
    .m12_o   (m12),
    .m20_o   (m20),
    .m21_o   (m21),
    .m22_o   (m22)
  );

  // The translations ride along in a delay line clocked by the same enables.
  always_ff @(posedge clk_i) begin
    if (en_flat[0]) begin
      trans_q[0] <= s_axis_tdata[3*TW-1:0];
    end
    for (int k = 1; k < Depth; k++) begin
      if (en_flat[k]) begin
        trans_q[k] <= trans_q[k-1];
      end
    end
  end

  assign m_axis_tdata = {trans_q[Depth-1], m22, m21, m20, m12, m11, m10, m02, m01, m00};

  `EBRM_ASSERT_IMP(a_m00_range, m_axis_tvalid,
                   m00 <= 16'sd16384 && m00 >= -16'sd16384, "m00 outside plus or minus one")
  `EBRM_ASSERT_IMP(a_m11_range, m_axis_tvalid,
                   m11 <= 16'sd16384 && m11 >= -16'sd16384, "m11 outside plus or minus one")
  `EBRM_ASSERT_IMP(a_m21_range, m_axis_tvalid,
                   m21 <= 16'sd16384 && m21 >= -16'sd16384, "m21 outside plus or minus one")

endmodule

`default_nettype wire
